FILE: rtl/mswd_pkg.sv
// Shared types and constants of the motor stall vote watchdog.
`default_nettype none
package mswd_pkg;

	// Register indexes on the configuration port
	localparam logic [2:0] REG_ENABLE    = 3'd0;
	localparam logic [2:0] REG_STEPS     = 3'd1;
	localparam logic [2:0] REG_STALL_THR = 3'd2;
	localparam logic [2:0] REG_MIN_SPEED = 3'd3;
	localparam logic [2:0] REG_ARM_RUNS  = 3'd4;
	localparam logic [2:0] REG_TRIP_RUNS = 3'd5;

	localparam int unsigned PADDR_W = 5;

	// Register reset values
	localparam logic [15:0] STEPS_RESET     = 16'd3200;
	localparam logic [17:0] MIN_SPEED_RESET = 18'd3200;
	localparam logic [7:0]  ARM_RUNS_RESET  = 8'd5;
	localparam logic [3:0]  TRIP_RUNS_RESET = 4'd3;

	// floor(x / 10) for 16-bit x as (x * 0xCCCD) >> 19
	localparam logic [15:0] DIV10_MUL   = 16'hCCCD;
	localparam int unsigned DIV10_SHIFT = 19;

	localparam logic [3:0] BAD_MAX = 4'd15;

	// Depth of the queue between front and back
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic        enable;
		logic [15:0] steps_per_rev;
		logic [9:0]  stall_threshold;
		logic [17:0] min_speed;
		logic [7:0]  arm_runs;
		logic [3:0]  trip_runs;
	} cfg_t;

	// One classified revolution, front to back
	typedef struct packed {
		logic        active;    // watchdog enabled when taken
		logic        first;     // baseline pulse, no judgement
		logic        below;     // under minimum speed
		logic        vote_period;
		logic        vote_steps;
		logic        vote_stall;
		logic [17:0] speed;
		logic [31:0] delta;
	} rev_t;

endpackage
`default_nettype wire

FILE: rtl/mswd_if.sv
// Handshake channels for revolution samples and verdicts.
`default_nettype none
interface mswd_sample_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] position;
	logic [15:0]        period_ms;
	logic [17:0]        speed;
	logic [9:0]         stall_reading;
	logic               profile_ok;
	logic [19:0]        expected_period;
	logic [19:0]        period_sigma;

	modport source (output valid, position, period_ms, speed, stall_reading, profile_ok,
		expected_period, period_sigma, input ready);
	modport sink (input valid, position, period_ms, speed, stall_reading, profile_ok,
		expected_period, period_sigma, output ready);
endinterface

interface mswd_verdict_if;
	logic               valid;
	logic               ready;
	logic               judged;
	logic               trip;
	logic               armed;
	logic               tripped;
	logic [2:0]         fault_code;
	logic [3:0]         bad_count;
	logic [7:0]         good_count;
	logic signed [31:0] step_delta;

	modport source (output valid, judged, trip, armed, tripped, fault_code, bad_count,
		good_count, step_delta, input ready);
	modport sink (input valid, judged, trip, armed, tripped, fault_code, bad_count,
		good_count, step_delta, output ready);
endinterface
`default_nettype wire

FILE: rtl/motor_stall_vote_watchdog_unit.sv
// Top level of the motor stall vote watchdog.
//
// One sample enters on the sample channel per tacho revolution pulse; one verdict
// leaves on the verdict channel for every sample, in order. Both channels transfer
// when valid and ready are high at a rising edge of clk.
// The front end computes the step delta and the period, step and stall votes in the
// cycle of the transfer and writes the classified revolution into a two-entry queue.
// The back end pops it, updates arming, run counters and trip state and loads the
// verdict register when that register is empty or its verdict is being taken.
// Throughput is one sample per cycle while the receiver keeps verdict.ready high.
// When the receiver stalls the verdict register holds, the queue fills with two
// more samples and sample.ready then drops until the verdict is taken.
// The user must write the registers over the APB-style port (byte address 4 * index)
// only while the block is idle; the block does not enforce this. Writing enable
// restarts the baseline pulse; writing 0 also clears arming and the run counters.
// arst_n clears the queue, the verdict valid and all watchdog state at once; the
// registers return to their reset values. No clearing pass follows reset.
`default_nettype none
module motor_stall_vote_watchdog_unit
	import mswd_pkg::*;
#(
	parameter int unsigned POSITION_WIDTH   = 32,
	parameter int unsigned GOOD_COUNT_WIDTH = 8
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [31:0]        pwdata,
	output logic      [31:0]        prdata,
	output logic                    pready,
	mswd_sample_if.sink    sample,
	mswd_verdict_if.source verdict
);

	cfg_t cfg;
	logic enable_wr;
	logic push;
	rev_t push_data;
	logic queue_full;
	logic not_empty;
	logic pop;
	rev_t head;

	mswd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.cfg       (cfg),
		.enable_wr (enable_wr)
	);

	mswd_front #(
		.POSITION_WIDTH (POSITION_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.enable_wr  (enable_wr),
		.sample     (sample),
		.queue_full (queue_full),
		.push       (push),
		.push_data  (push_data)
	);

	mswd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (queue_full),
		.not_empty (not_empty),
		.pop       (pop),
		.head      (head)
	);

	mswd_back #(
		.GOOD_COUNT_WIDTH (GOOD_COUNT_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.enable_wr (enable_wr),
		.not_empty (not_empty),
		.head      (head),
		.pop       (pop),
		.verdict   (verdict)
	);

endmodule
`default_nettype wire

FILE: rtl/mswd_cfg.sv
// Configuration registers behind the APB-style port.
`default_nettype none
module mswd_cfg
	import mswd_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [31:0]        pwdata,
	output logic      [31:0]        prdata,
	output logic                    pready,
	output cfg_t                    cfg,
	output logic                    enable_wr
);

	cfg_t        cfg_q;
	logic        wr_en;
	logic [2:0]  idx;

	assign pready = 1'b1;
	assign idx    = paddr[PADDR_W-1:2];
	assign wr_en  = psel & penable & pwrite;
	assign cfg    = cfg_q;
	assign enable_wr = wr_en && (idx == REG_ENABLE);

	// Write registers on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable          <= 1'b0;
			cfg_q.steps_per_rev   <= STEPS_RESET;
			cfg_q.stall_threshold <= '0;
			cfg_q.min_speed       <= MIN_SPEED_RESET;
			cfg_q.arm_runs        <= ARM_RUNS_RESET;
			cfg_q.trip_runs       <= TRIP_RUNS_RESET;
		end else if (wr_en) begin
			case (idx)
				REG_ENABLE:    cfg_q.enable          <= pwdata[0];
				REG_STEPS:     cfg_q.steps_per_rev   <= pwdata[15:0];
				REG_STALL_THR: cfg_q.stall_threshold <= pwdata[9:0];
				REG_MIN_SPEED: cfg_q.min_speed       <= pwdata[17:0];
				REG_ARM_RUNS:  cfg_q.arm_runs        <= pwdata[7:0];
				REG_TRIP_RUNS: cfg_q.trip_runs       <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		case (idx)
			REG_ENABLE:    prdata = 32'(cfg_q.enable);
			REG_STEPS:     prdata = 32'(cfg_q.steps_per_rev);
			REG_STALL_THR: prdata = 32'(cfg_q.stall_threshold);
			REG_MIN_SPEED: prdata = 32'(cfg_q.min_speed);
			REG_ARM_RUNS:  prdata = 32'(cfg_q.arm_runs);
			REG_TRIP_RUNS: prdata = 32'(cfg_q.trip_runs);
			default:       prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

FILE: rtl/mswd_front.sv
// Front end: takes samples, tracks position and casts the three votes.
`default_nettype none
module mswd_front
	import mswd_pkg::*;
#(
	parameter int unsigned POSITION_WIDTH = 32
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cfg_t cfg,
	input  wire logic enable_wr,
	mswd_sample_if.sink sample,
	input  wire logic queue_full,
	output logic      push,
	output rev_t      push_data
);

	localparam int unsigned PW = POSITION_WIDTH;
	localparam int unsigned CW = (PW > 16) ? PW : 16;

	logic          first_q;
	logic [PW-1:0] last_pos_q;

	logic [PW-1:0] pos_w;
	logic [PW-1:0] delta;
	logic [PW-1:0] mag;
	logic [CW-1:0] mag_w;
	logic [CW-1:0] spr_w;
	logic [CW-1:0] step_err;
	logic [31:0]   div_prod;
	logic [CW-1:0] step_tol;
	logic [20:0]   period_x16;
	logic [20:0]   expected_w;
	logic [20:0]   period_err;
	logic [21:0]   period_tol;
	logic          vote_period;
	logic          vote_steps;
	logic          vote_stall;

	assign sample.ready = !queue_full;
	assign push         = sample.valid & !queue_full;

	// Position delta, wrapped to the position width
	assign pos_w = PW'(sample.position);
	assign delta = pos_w - last_pos_q;
	assign mag   = delta[PW-1] ? (~delta + 1'b1) : delta;

	// Step vote: | |delta| - steps_per_rev | > floor(steps_per_rev / 10)
	assign mag_w    = CW'(mag);
	assign spr_w    = CW'(cfg.steps_per_rev);
	assign step_err = (mag_w > spr_w) ? (mag_w - spr_w) : (spr_w - mag_w);
	assign div_prod = cfg.steps_per_rev * DIV10_MUL;
	assign step_tol = CW'(div_prod >> DIV10_SHIFT);
	assign vote_steps = (cfg.steps_per_rev != '0) && (step_err > step_tol);

	// Period vote: |16 * period - expected| > 3 * sigma
	assign period_x16 = {1'b0, sample.period_ms, 4'b0000};
	assign expected_w = {1'b0, sample.expected_period};
	assign period_err = (period_x16 > expected_w) ? (period_x16 - expected_w)
		: (expected_w - period_x16);
	assign period_tol = {2'b00, sample.period_sigma} + {1'b0, sample.period_sigma, 1'b0};
	assign vote_period = sample.profile_ok && ({1'b0, period_err} > period_tol);

	// Stall vote
	assign vote_stall = (cfg.stall_threshold != '0)
		&& (sample.stall_reading < cfg.stall_threshold);

	// Classify the sample for the back end
	always_comb begin
		push_data.active      = cfg.enable;
		push_data.first       = first_q;
		push_data.below       = sample.speed < cfg.min_speed;
		push_data.vote_period = vote_period;
		push_data.vote_steps  = vote_steps;
		push_data.vote_stall  = vote_stall;
		push_data.speed       = sample.speed;
		push_data.delta       = (cfg.enable && !first_q) ? 32'(delta) : '0;
	end

	// Hold baseline position; rearm first pulse on each enable write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q    <= 1'b1;
			last_pos_q <= '0;
		end else if (enable_wr) begin
			first_q <= 1'b1;
		end else if (push && cfg.enable) begin
			first_q    <= 1'b0;
			last_pos_q <= pos_w;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/mswd_queue.sv
// Short queue of classified revolutions between front and back.
`default_nettype none
module mswd_queue
	import mswd_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire rev_t push_data,
	output logic      full,
	output logic      not_empty,
	input  wire logic pop,
	output rev_t      head
);

	rev_t              entries_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full      = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = entries_q[rd_ptr_q];

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

FILE: rtl/mswd_back.sv
// Back end: run counters, arming and trip decision, verdict register.
`default_nettype none
module mswd_back
	import mswd_pkg::*;
#(
	parameter int unsigned GOOD_COUNT_WIDTH = 8
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cfg_t cfg,
	input  wire logic enable_wr,
	input  wire logic not_empty,
	input  wire rev_t head,
	output logic      pop,
	mswd_verdict_if.source verdict
);

	localparam int unsigned GW  = GOOD_COUNT_WIDTH;
	localparam int unsigned GW2 = (GW > 8) ? GW : 8;

	logic          armed_q;
	logic          tripped_q;
	logic [3:0]    bad_q;
	logic [GW-1:0] good_q;
	logic [17:0]   armed_speed_q;
	logic [2:0]    code_q;
	logic          valid_q;
	logic          enable_wr_q;

	logic          armed_n;
	logic          tripped_n;
	logic [3:0]    bad_n;
	logic [GW-1:0] good_n;
	logic [17:0]   armed_speed_n;
	logic [2:0]    code_n;
	logic          judged_n;
	logic          trip_n;

	logic [17:0]   speed_diff;
	logic [22:0]   speed_diff25;
	logic [22:0]   speed_tol;
	logic          drift;
	logic          bad_rev;

	assign pop = not_empty && (!valid_q || verdict.ready);

	// Speed drift: 25 * |speed - armed_speed| > 2 * armed_speed
	assign speed_diff = (head.speed > armed_speed_q) ? (head.speed - armed_speed_q)
		: (armed_speed_q - head.speed);
	assign speed_diff25 = {speed_diff, 4'b0000} + {1'b0, speed_diff, 3'b000}
		+ 23'(speed_diff);
	assign speed_tol = 23'({armed_speed_q, 1'b0});
	assign drift     = speed_diff25 > speed_tol;

	// Two of three votes
	assign bad_rev = (head.vote_period & head.vote_steps)
		| (head.vote_period & head.vote_stall)
		| (head.vote_steps & head.vote_stall);

	// Next state for the revolution at the head of the queue
	always_comb begin
		armed_n       = armed_q;
		tripped_n     = tripped_q;
		bad_n         = bad_q;
		good_n        = good_q;
		armed_speed_n = armed_speed_q;
		code_n        = code_q;
		judged_n      = 1'b0;
		trip_n        = 1'b0;
		if (head.active && !head.first) begin
			if (head.below) begin
				good_n = '0;
			end else begin
				judged_n = 1'b1;
				if (armed_n && drift) begin
					armed_n       = 1'b0;
					good_n        = '0;
					bad_n         = '0;
					armed_speed_n = '0;
				end
				if (bad_rev) begin
					if (armed_n) begin
						if (bad_n != BAD_MAX) begin
							bad_n = bad_n + 1'b1;
						end
						code_n = {head.vote_period, head.vote_steps, head.vote_stall};
						if (bad_n >= cfg.trip_runs) begin
							tripped_n = 1'b1;
							armed_n   = 1'b0;
							trip_n    = 1'b1;
						end
					end
					good_n = '0;
				end else begin
					bad_n = '0;
					if (good_n != '1) begin
						good_n = good_n + 1'b1;
					end
					if (!armed_n && (GW2'(good_n) >= GW2'(cfg.arm_runs))) begin
						armed_n       = 1'b1;
						tripped_n     = 1'b0;
						armed_speed_n = head.speed;
					end
				end
			end
		end
	end

	// Delay the enable write strobe so the new enable value is visible
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_wr_q <= 1'b0;
		end else begin
			enable_wr_q <= enable_wr;
		end
	end

	// Update watchdog state; clear runs and arming the cycle after enable is written to 0
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q       <= 1'b0;
			tripped_q     <= 1'b0;
			bad_q         <= '0;
			good_q        <= '0;
			armed_speed_q <= '0;
			code_q        <= '0;
		end else if (enable_wr_q) begin
			if (!cfg.enable) begin
				armed_q <= 1'b0;
				good_q  <= '0;
				bad_q   <= '0;
			end
		end else if (pop) begin
			armed_q       <= armed_n;
			tripped_q     <= tripped_n;
			bad_q         <= bad_n;
			good_q        <= good_n;
			armed_speed_q <= armed_speed_n;
			code_q        <= code_n;
		end
	end

	// Verdict valid: set on pop, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (verdict.ready) begin
			valid_q <= 1'b0;
		end
	end

	// Verdict payload
	always_ff @(posedge clk) begin
		if (pop) begin
			verdict.judged     <= judged_n;
			verdict.trip       <= trip_n;
			verdict.armed      <= armed_n;
			verdict.tripped    <= tripped_n;
			verdict.fault_code <= code_n;
			verdict.bad_count  <= bad_n;
			verdict.good_count <= 8'(good_n);
			verdict.step_delta <= head.delta;
		end
	end

	assign verdict.valid = valid_q;

endmodule
`default_nettype wire
